// ----- design/rbd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rbd_pkg;

	// deque geometry
	localparam int CAPACITY   = 255;
	localparam int DATA_WIDTH = 8;
	localparam int RING_SLOTS = CAPACITY + 1;
	localparam int PTR_W      = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
	localparam int OCC_W      = 8;
	localparam int OP_W       = 3;

	typedef logic [PTR_W-1:0]      ptr_t;
	typedef logic [DATA_WIDTH-1:0] data_t;
	typedef logic [OCC_W-1:0]      occ_t;

	// request codes
	typedef enum logic [OP_W-1:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_PEEK_FRONT = 3'd4,
		OP_CLEAR      = 3'd5
	} op_t;

	localparam ptr_t PTR_LAST = ptr_t'(RING_SLOTS - 1);

	// one step forward around the ring
	function automatic ptr_t ring_next(input ptr_t p);
		ring_next = (p == PTR_LAST) ? '0 : ptr_t'(p + 1'b1);
	endfunction

	// one step backward around the ring
	function automatic ptr_t ring_prev(input ptr_t p);
		ring_prev = (p == '0) ? PTR_LAST : ptr_t'(p - 1'b1);
	endfunction

endpackage

`default_nettype wire

// ----- design/rbd_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// request channel: one deque operation per item
interface rbd_req_if;
	logic                      valid;
	logic                      ready;
	logic [rbd_pkg::OP_W-1:0]  operation;
	logic [7:0]                item_in;

	modport source (output valid, output operation, output item_in, input ready);
	modport sink   (input valid, input operation, input item_in, output ready);
endinterface

// response channel: one result item per request
interface rbd_rsp_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic [7:0]  item_out;
	logic [7:0]  occupancy;
	logic        is_empty;

	modport source (output valid, output ok, output item_out, output occupancy,
		output is_empty, input ready);
	modport sink   (input valid, input ok, input item_out, input occupancy,
		input is_empty, output ready);
endinterface

`default_nettype wire

// ----- design/ring_buffer_deque.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Byte deque held in a ring of CAPACITY+1 slots (at most CAPACITY items).
// Request channel (req): operation (push back, push front, pop front,
// pop back, peek front, clear) and item_in, the byte to push.
// Response channel (rsp): ok, item_out (popped or peeked byte, else 0),
// occupancy after the request (saturated at 255) and is_empty.
// Every request gives exactly one response item, in order.
// Response: registered, valid in the cycle after the request is taken.
// Throughput: one request per cycle while rsp.ready is high; pointers update
// at the accept edge and the slot RAM is read there, so back-to-back requests
// see each other's effects with no bubble.
// Stall: the response register holds while rsp.ready is low; req.ready
// stays high as long as the response register is empty or being drained
// in the same cycle.
// Reset: arst_n clears both pointers (empty deque) and the response valid.
// Slot contents are not cleared; the pointers never expose unwritten slots.
// Requests with codes 6 and 7 answer ok=0 and leave the state unchanged.

module ring_buffer_deque (
	input  wire logic   clk,
	input  wire logic   arst_n,
	rbd_req_if.sink     req,
	rbd_rsp_if.source   rsp
);

	rbd_pkg::ptr_t  head_q, tail_q;
	rbd_pkg::ptr_t  head_nx, tail_nx;
	rbd_pkg::ptr_t  wr_addr, rd_addr;
	rbd_pkg::ptr_t  count;
	rbd_pkg::data_t mem [rbd_pkg::RING_SLOTS];
	rbd_pkg::data_t rd_data_q;
	rbd_pkg::data_t item;
	rbd_pkg::op_t   op;
	logic           accept;
	logic           is_empty_now;
	logic           wr_en, rd_en, ok_nx;
	logic           valid_q, ok_q, rd_q, empty_q;
	rbd_pkg::occ_t  occ_q, occ_nx;

	assign accept       = req.valid && req.ready;
	assign req.ready    = !valid_q || rsp.ready;
	assign op           = rbd_pkg::op_t'(req.operation);
	assign item         = rbd_pkg::DATA_WIDTH'(req.item_in);
	assign is_empty_now = (head_q == tail_q);

	// decode request: next pointers, slot write and slot read
	always_comb begin
		head_nx = head_q;
		tail_nx = tail_q;
		wr_addr = tail_q;
		rd_addr = tail_q;
		wr_en   = 1'b0;
		rd_en   = 1'b0;
		ok_nx   = 1'b0;
		unique case (op)
			rbd_pkg::OP_PUSH_BACK: begin
				if (rbd_pkg::ring_next(tail_q) != head_q) begin
					tail_nx = rbd_pkg::ring_next(tail_q);
					wr_addr = rbd_pkg::ring_next(tail_q);
					wr_en   = 1'b1;
					ok_nx   = 1'b1;
				end
			end
			rbd_pkg::OP_PUSH_FRONT: begin
				if (rbd_pkg::ring_prev(head_q) != tail_q) begin
					wr_addr = head_q;
					head_nx = rbd_pkg::ring_prev(head_q);
					wr_en   = 1'b1;
					ok_nx   = 1'b1;
				end
			end
			rbd_pkg::OP_POP_FRONT: begin
				if (!is_empty_now) begin
					head_nx = rbd_pkg::ring_next(head_q);
					rd_addr = rbd_pkg::ring_next(head_q);
					rd_en   = 1'b1;
					ok_nx   = 1'b1;
				end
			end
			rbd_pkg::OP_POP_BACK: begin
				if (!is_empty_now) begin
					rd_addr = tail_q;
					tail_nx = rbd_pkg::ring_prev(tail_q);
					rd_en   = 1'b1;
					ok_nx   = 1'b1;
				end
			end
			rbd_pkg::OP_PEEK_FRONT: begin
				if (!is_empty_now) begin
					rd_addr = rbd_pkg::ring_next(head_q);
					rd_en   = 1'b1;
					ok_nx   = 1'b1;
				end
			end
			rbd_pkg::OP_CLEAR: begin
				head_nx = '0;
				tail_nx = '0;
				ok_nx   = 1'b1;
			end
			default: begin
				ok_nx = 1'b0;
			end
		endcase
	end

	// occupancy after the request, saturated to the field width
	always_comb begin
		if (tail_nx >= head_nx) begin
			count = rbd_pkg::ptr_t'(tail_nx - head_nx);
		end else begin
			count = rbd_pkg::ptr_t'(tail_nx + rbd_pkg::ptr_t'(rbd_pkg::RING_SLOTS) - head_nx);
		end
		if ((rbd_pkg::PTR_W + 1)'(count) > (rbd_pkg::PTR_W + 1)'(8'hFF)) begin
			occ_nx = '1;
		end else begin
			occ_nx = rbd_pkg::OCC_W'(count);
		end
	end

	// slot RAM: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			mem[wr_addr] <= item;
		end
		if (accept && rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else if (accept) begin
			head_q <= head_nx;
			tail_q <= tail_nx;
		end
	end

	// response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q    <= ok_nx;
			rd_q    <= rd_en;
			occ_q   <= occ_nx;
			empty_q <= (head_nx == tail_nx);
		end
	end

	assign rsp.valid     = valid_q;
	assign rsp.ok        = ok_q;
	assign rsp.item_out  = rd_q ? 8'(rd_data_q) : 8'h00;
	assign rsp.occupancy = occ_q;
	assign rsp.is_empty  = empty_q;

endmodule

`default_nettype wire
